@@ rtl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the Fresnel reflectance block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising clock edge, masked while reset is asserted.
`define FRL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property at each rising clock edge, reset included.
`define FRL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/frl_pkg.sv @@
// Types and constants shared by the Fresnel reflectance pipeline.
`default_nettype none
package frl_pkg;
    localparam int AC_W    = 29;
    localparam int IDX_W   = 16;
    localparam int RAT_W   = 31;
    localparam int NUMD_W  = 62;
    localparam int DEN_W   = 32;
    localparam int SINT_W  = 30;
    localparam int ROOT_N  = 31;
    localparam int ROOT_VW = 61;

    localparam logic [IDX_W-1:0] IDX_ONE = 16'd4096;
    localparam logic [16:0]      ONE_Q15 = 17'd32768;

    typedef struct packed {
        logic tir;
        logic zero_s;
    } t_flags;

    typedef struct packed {
        logic             tir;
        logic             swap;
        logic [IDX_W-1:0] ri;
        logic [AC_W-1:0]  ac;
    } t_geom;
endpackage
`default_nettype wire

@@ rtl/fresnel_reflectance.sv @@
// Top level of the unpolarized Fresnel reflectance pipeline.
// One transaction enters and one result leaves per clock while the output is not
// stalled. From input to output register the pipe runs through five front stages
// for the dot product, clamp, squares and Snell product, a 30-stage divider for
// the transmitted sine, a 31-stage square root for the transmitted cosine, three
// stages for the Fresnel products and normalization, a 31-stage divider per
// polarization, a squaring stage and the output register. The whole pipe holds
// when a result waits at the output and the downstream side is not ready.
`default_nettype none
module fresnel_reflectance (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // incident_x, incident_y, incident_z, normal_x, normal_y, normal_z, refr_index
    input  wire logic [111:0] i_s_tdata,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // reflectance, transmittance
    output logic [31:0]       o_m_tdata,
    // total_internal
    output logic              o_m_tuser
);
    import frl_pkg::*;
    `include "assert_macros.svh"

    localparam logic signed [33:0] LIM_POS = 34'sd268435456;
    localparam logic signed [33:0] LIM_NEG = -34'sd268435456;

    logic en;
    logic r_out_vld;
    assign en         = !r_out_vld || i_m_tready;
    assign o_s_tready = en;

    logic signed [15:0] w_ix, w_iy, w_iz, w_nx, w_ny, w_nz;
    logic [IDX_W-1:0]   w_ri;
    assign w_ix = i_s_tdata[15:0];
    assign w_iy = i_s_tdata[31:16];
    assign w_iz = i_s_tdata[47:32];
    assign w_nx = i_s_tdata[63:48];
    assign w_ny = i_s_tdata[79:64];
    assign w_nz = i_s_tdata[95:80];
    assign w_ri = i_s_tdata[111:96];

    // stage 1: component products
    logic               r1_vld;
    logic signed [31:0] r1_px, r1_py, r1_pz;
    logic [IDX_W-1:0]   r1_ri;
    // stage 2: clamped cosine
    logic               r2_vld, r2_swap;
    logic [AC_W-1:0]    r2_ac;
    logic [IDX_W-1:0]   r2_ri;
    // stage 3: squares
    logic               r3_vld, r3_swap;
    logic [AC_W-1:0]    r3_ac;
    logic [IDX_W-1:0]   r3_ri;
    logic [57:0]        r3_acsq;
    logic [31:0]        r3_ei2, r3_et2;
    // stage 4: squared incident sine
    logic               r4_vld, r4_swap;
    logic [AC_W-1:0]    r4_ac;
    logic [IDX_W-1:0]   r4_ri;
    logic [30:0]        r4_s2;
    logic [31:0]        r4_ei2, r4_et2;
    // stage 5: Snell numerator
    logic               r5_vld, r5_swap;
    logic [AC_W-1:0]    r5_ac;
    logic [IDX_W-1:0]   r5_ri;
    logic [NUMD_W-1:0]  r5_num;
    logic [DEN_W-1:0]   r5_den;

    logic signed [33:0] w_dot, w_dotc;
    logic [IDX_W-1:0]   w2_ei, w2_et;
    logic [57:0]        w_inc;
    logic [62:0]        w_num;

    always_comb begin
        w_dot = 34'(r1_px) + 34'(r1_py) + 34'(r1_pz);
        if (w_dot > LIM_POS) begin
            w_dotc = LIM_POS;
        end else if (w_dot < LIM_NEG) begin
            w_dotc = LIM_NEG;
        end else begin
            w_dotc = w_dot;
        end
        w2_ei = r2_swap ? r2_ri : IDX_ONE;
        w2_et = r2_swap ? IDX_ONE : r2_ri;
        w_inc = (58'(1) << 56) - r3_acsq;
        w_num = 63'(r4_ei2) * 63'(r4_s2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_s_tvalid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_px   <= 32'(w_ix) * 32'(w_nx);
            r1_py   <= 32'(w_iy) * 32'(w_ny);
            r1_pz   <= 32'(w_iz) * 32'(w_nz);
            r1_ri   <= (w_ri == '0) ? IDX_W'(1) : w_ri;
            r2_swap <= w_dotc > 34'sd0;
            r2_ac   <= (w_dotc < 34'sd0) ? AC_W'(-w_dotc) : AC_W'(w_dotc);
            r2_ri   <= r1_ri;
            r3_acsq <= 58'(r2_ac) * 58'(r2_ac);
            r3_ei2  <= 32'(w2_ei) * 32'(w2_ei);
            r3_et2  <= 32'(w2_et) * 32'(w2_et);
            r3_ac   <= r2_ac;
            r3_ri   <= r2_ri;
            r3_swap <= r2_swap;
            r4_s2   <= w_inc[56:26];
            r4_ei2  <= r3_ei2;
            r4_et2  <= r3_et2;
            r4_ac   <= r3_ac;
            r4_ri   <= r3_ri;
            r4_swap <= r3_swap;
            r5_num  <= w_num[NUMD_W-1:0];
            r5_den  <= r4_et2;
            r5_ac   <= r4_ac;
            r5_ri   <= r4_ri;
            r5_swap <= r4_swap;
        end
    end

    // transmitted sine squared
    t_geom             w5_geom, w_d1_geom, w_sq_geom;
    logic              w_d1_vld, w_sq_vld;
    logic [SINT_W-1:0] w_sint2;
    logic [30:0]       w_cos2;
    logic [RAT_W-1:0]  w_cost;

    assign w5_geom.tir  = r5_num >= {r5_den, 30'b0};
    assign w5_geom.swap = r5_swap;
    assign w5_geom.ri   = r5_ri;
    assign w5_geom.ac   = r5_ac;

    frl_div #(
        .NUM_W(NUMD_W), .DEN_W(DEN_W), .Q_W(SINT_W), .SB_W($bits(t_geom))
    ) u_div_sint (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_vld(r5_vld), .i_num(r5_num), .i_den(r5_den), .i_sb(w5_geom),
        .o_vld(w_d1_vld), .o_quo(w_sint2), .o_sb(w_d1_geom)
    );

    assign w_cos2 = (31'(1) << 30) - 31'(w_sint2);

    frl_sqrt #(
        .V_W(ROOT_VW), .N(ROOT_N), .SB_W($bits(t_geom))
    ) u_sqrt_cos (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_vld(w_d1_vld), .i_val({w_cos2, 30'b0}), .i_sb(w_d1_geom),
        .o_vld(w_sq_vld), .o_root(w_cost), .o_sb(w_sq_geom)
    );

    // stage 6: Fresnel products
    logic             r6_vld, r6_tir;
    logic [46:0]      r6_as, r6_bs, r6_ap, r6_bp;
    logic [IDX_W-1:0] w6_ei, w6_et;
    logic [30:0]      w6_ac30;
    // stage 7: sums and differences
    logic             r7_vld, r7_tir;
    logic [47:0]      r7_den_s, r7_den_p;
    logic [46:0]      r7_dif_s, r7_dif_p;
    // stage 8: normalization
    logic             r8_vld;
    t_flags           r8_flags;
    logic             r8_zero_p;
    logic [31:0]      r8_den_s, r8_den_p, r8_dif_s, r8_dif_p;
    logic [4:0]       w_sh_s, w_sh_p;

    assign w6_ei   = w_sq_geom.swap ? w_sq_geom.ri : IDX_ONE;
    assign w6_et   = w_sq_geom.swap ? IDX_ONE : w_sq_geom.ri;
    assign w6_ac30 = {w_sq_geom.ac, 2'b00};

    always_comb begin
        w_sh_s = '0;
        w_sh_p = '0;
        for (int i = 0; i < 16; i++) begin
            if (r7_den_s[32+i]) begin
                w_sh_s = 5'(i + 1);
            end
            if (r7_den_p[32+i]) begin
                w_sh_p = 5'(i + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
            r8_vld <= 1'b0;
        end else if (en) begin
            r6_vld <= w_sq_vld;
            r7_vld <= r6_vld;
            r8_vld <= r7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_as           <= 47'(w6_et) * 47'(w6_ac30);
            r6_bs           <= 47'(w6_ei) * 47'(w_cost);
            r6_ap           <= 47'(w6_ei) * 47'(w6_ac30);
            r6_bp           <= 47'(w6_et) * 47'(w_cost);
            r6_tir          <= w_sq_geom.tir;
            r7_den_s        <= 48'(r6_as) + 48'(r6_bs);
            r7_den_p        <= 48'(r6_ap) + 48'(r6_bp);
            r7_dif_s        <= (r6_as > r6_bs) ? r6_as - r6_bs : r6_bs - r6_as;
            r7_dif_p        <= (r6_ap > r6_bp) ? r6_ap - r6_bp : r6_bp - r6_ap;
            r7_tir          <= r6_tir;
            r8_den_s        <= 32'(r7_den_s >> w_sh_s);
            r8_den_p        <= 32'(r7_den_p >> w_sh_p);
            r8_dif_s        <= 32'(r7_dif_s >> w_sh_s);
            r8_dif_p        <= 32'(r7_dif_p >> w_sh_p);
            r8_flags.tir    <= r7_tir;
            r8_flags.zero_s <= r7_den_s == '0;
            r8_zero_p       <= r7_den_p == '0;
        end
    end

    logic             w_rs_vld, w_rp_vld, w_zero_p;
    logic [RAT_W-1:0] w_rs, w_rp;
    t_flags           w_flags;

    frl_div #(
        .NUM_W(NUMD_W), .DEN_W(DEN_W), .Q_W(RAT_W), .SB_W($bits(t_flags))
    ) u_div_rs (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_vld(r8_vld), .i_num({r8_dif_s, 30'b0}), .i_den(r8_den_s), .i_sb(r8_flags),
        .o_vld(w_rs_vld), .o_quo(w_rs), .o_sb(w_flags)
    );

    frl_div #(
        .NUM_W(NUMD_W), .DEN_W(DEN_W), .Q_W(RAT_W), .SB_W(1)
    ) u_div_rp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_vld(r8_vld), .i_num({r8_dif_p, 30'b0}), .i_den(r8_den_p), .i_sb(r8_zero_p),
        .o_vld(w_rp_vld), .o_quo(w_rp), .o_sb(w_zero_p)
    );

    // stage 9: squared ratios; stage 10: output register
    logic        r9_vld, r9_tir;
    logic [61:0] r9_rs2, r9_rp2;
    logic [62:0] w_sum;
    logic [16:0] w_kr, w_krs;
    logic [15:0] r_refl, r_trans;
    logic        r_tir;

    always_comb begin
        w_sum = 63'(r9_rs2) + 63'(r9_rp2) + (63'(1) << 45);
        w_kr  = w_sum[62:46];
        w_krs = (r9_tir || w_kr > ONE_Q15) ? ONE_Q15 : w_kr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r9_vld    <= w_rs_vld & w_rp_vld;
            r_out_vld <= r9_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_rs2  <= w_flags.zero_s ? (62'(1) << 60) : 62'(w_rs) * 62'(w_rs);
            r9_rp2  <= w_zero_p ? (62'(1) << 60) : 62'(w_rp) * 62'(w_rp);
            r9_tir  <= w_flags.tir;
            r_refl  <= w_krs[15:0];
            r_trans <= 16'(ONE_Q15 - w_krs);
            r_tir   <= r9_tir;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {r_trans, r_refl};
    assign o_m_tuser  = r_tir;

    `FRL_ASSERT(a_sum_one, o_m_tvalid |-> (17'(r_refl) + 17'(r_trans) == ONE_Q15),
        "reflectance and transmittance do not sum to one")
    `FRL_ASSERT(a_tir_full, (o_m_tvalid && r_tir) |-> (17'(r_refl) == ONE_Q15),
        "total internal reflection without full reflectance")
    `FRL_ASSERT_ALWAYS(a_stall_hold, (o_m_tvalid && !i_m_tready) |-> !o_s_tready,
        "input taken while the output stalls")
endmodule
`default_nettype wire

@@ rtl/frl_div.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none
module frl_div #(
    parameter int NUM_W = 62,
    parameter int DEN_W = 32,
    parameter int Q_W   = 30,
    parameter int SB_W  = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_vld,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    input  wire logic [SB_W-1:0]  i_sb,
    output logic                  o_vld,
    output logic [Q_W-1:0]        o_quo,
    output logic [SB_W-1:0]       o_sb
);
    import frl_pkg::*;

    logic [NUM_W-1:0] s_rem [Q_W+1];
    logic [DEN_W-1:0] s_den [Q_W+1];
    logic [Q_W-1:0]   s_quo [Q_W+1];
    logic [SB_W-1:0]  s_sb  [Q_W+1];
    logic [Q_W:0]     s_vld;

    assign s_rem[0] = i_num;
    assign s_den[0] = i_den;
    assign s_quo[0] = '0;
    assign s_sb[0]  = i_sb;
    assign s_vld[0] = i_vld;

    for (genvar g = 0; g < Q_W; g++) begin : g_stage
        localparam int SH = Q_W - 1 - g;
        logic [NUM_W-1:0] w_trial;
        logic             w_ge;
        logic [NUM_W-1:0] r_rem;
        logic [DEN_W-1:0] r_den;
        logic [Q_W-1:0]   r_quo;
        logic [SB_W-1:0]  r_sb;
        logic             r_vld;

        assign w_trial = NUM_W'(s_den[g]) << SH;
        assign w_ge    = s_rem[g] >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= s_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= w_ge ? s_rem[g] - w_trial : s_rem[g];
                r_quo <= s_quo[g] | (Q_W'(w_ge) << SH);
                r_den <= s_den[g];
                r_sb  <= s_sb[g];
            end
        end

        assign s_rem[g+1] = r_rem;
        assign s_den[g+1] = r_den;
        assign s_quo[g+1] = r_quo;
        assign s_sb[g+1]  = r_sb;
        assign s_vld[g+1] = r_vld;
    end

    assign o_vld = s_vld[Q_W];
    assign o_quo = s_quo[Q_W];
    assign o_sb  = s_sb[Q_W];
endmodule
`default_nettype wire

@@ rtl/frl_sqrt.sv @@
// Pipelined integer square root, one result bit per register stage.
`default_nettype none
module frl_sqrt #(
    parameter int V_W  = 61,
    parameter int N    = 31,
    parameter int SB_W = 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_vld,
    input  wire logic [V_W-1:0]  i_val,
    input  wire logic [SB_W-1:0] i_sb,
    output logic                 o_vld,
    output logic [N-1:0]         o_root,
    output logic [SB_W-1:0]      o_sb
);
    import frl_pkg::*;

    logic [V_W-1:0]  s_v   [N+1];
    logic [V_W:0]    s_res [N+1];
    logic [SB_W-1:0] s_sb  [N+1];
    logic [N:0]      s_vld;

    assign s_v[0]   = i_val;
    assign s_res[0] = '0;
    assign s_sb[0]  = i_sb;
    assign s_vld[0] = i_vld;

    for (genvar g = 0; g < N; g++) begin : g_stage
        localparam int BP = 2 * (N - 1 - g);
        logic [V_W:0]    w_bit;
        logic [V_W:0]    w_trial;
        logic            w_ge;
        logic [V_W-1:0]  r_v;
        logic [V_W:0]    r_res;
        logic [SB_W-1:0] r_sb;
        logic            r_vld;

        assign w_bit   = (V_W+1)'(1) << BP;
        assign w_trial = s_res[g] + w_bit;
        assign w_ge    = {1'b0, s_v[g]} >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= s_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v   <= w_ge ? V_W'({1'b0, s_v[g]} - w_trial) : s_v[g];
                r_res <= w_ge ? (s_res[g] >> 1) + w_bit : s_res[g] >> 1;
                r_sb  <= s_sb[g];
            end
        end

        assign s_v[g+1]   = r_v;
        assign s_res[g+1] = r_res;
        assign s_sb[g+1]  = r_sb;
        assign s_vld[g+1] = r_vld;
    end

    assign o_vld  = s_vld[N];
    assign o_root = s_res[N][N-1:0];
    assign o_sb   = s_sb[N];
endmodule
`default_nettype wire

@@ bench/fresnel_reflectance_test.sv @@
// Testbench for the Fresnel reflectance pipeline: random and directed vectors checked by a scoreboard.
`timescale 1ns / 100ps
`default_nettype none
module fresnel_reflectance_test;
    import frl_pkg::*;

    typedef struct packed {
        logic [15:0] refl;
        logic [15:0] trans;
        logic        tir;
    } t_fresnel;

    class reflectance_board;
        t_fresnel pending[$];
        int       errors;

        function automatic logic [63:0] int_sqrt(logic [63:0] v);
            logic [63:0] res;
            logic [63:0] bitv;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (v >= res + bitv) begin
                    v   = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        function automatic logic [63:0] amp_sq(logic [63:0] a, logic [63:0] b);
            logic [63:0] den;
            logic [63:0] d;
            logic [63:0] r;
            den = a + b;
            d   = (a > b) ? a - b : b - a;
            if (den == 0) return 64'd1 << 60;
            while (den >= (64'd1 << 32)) begin
                den = den >> 1;
                d   = d >> 1;
            end
            r = (d << 30) / den;
            return r * r;
        endfunction

        function automatic t_fresnel fresnel(logic [111:0] w);
            longint      dotp;
            longint      lim;
            logic [63:0] ri, ei, et, ac, s2, num, den, sint2, cost, ac30, kr;
            t_fresnel    o;
            dotp = longint'($signed(w[15:0])) * longint'($signed(w[63:48]))
                 + longint'($signed(w[31:16])) * longint'($signed(w[79:64]))
                 + longint'($signed(w[47:32])) * longint'($signed(w[95:80]));
            lim = 64'sd1 << 28;
            ri  = {48'd0, w[111:96]};
            if (ri == 0) ri = 1;
            ei = 4096;
            et = ri;
            if (dotp > lim) dotp = lim;
            if (dotp < -lim) dotp = -lim;
            if (dotp > 0) begin
                ei = ri;
                et = 4096;
            end
            ac  = (dotp < 0) ? -dotp : dotp;
            s2  = ((64'd1 << 56) - ac * ac) >> 26;
            num = ei * ei * s2;
            den = et * et;
            o.tir = 0;
            if (num >= (den << 30)) begin
                o.tir = 1;
                kr = 32768;
            end else begin
                sint2 = num / den;
                cost  = int_sqrt(((64'd1 << 30) - sint2) << 30);
                ac30  = ac << 2;
                kr = (amp_sq(et * ac30, ei * cost) + amp_sq(ei * ac30, et * cost)
                      + (64'd1 << 45)) >> 46;
                if (kr > 32768) kr = 32768;
            end
            o.refl  = kr[15:0];
            o.trans = 16'(32768 - kr);
            return o;
        endfunction

        function void note_input(logic [111:0] w);
            pending = {pending, fresnel(w)};
        endfunction

        function void check_result(logic [31:0] data, logic user);
            t_fresnel e;
            if (pending.size() == 0) begin
                $error("unexpected result %h", data);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (data[15:0] !== e.refl) begin
                $error("reflectance expected %0d actual %0d", e.refl, data[15:0]);
                errors++;
            end
            if (data[31:16] !== e.trans) begin
                $error("transmittance expected %0d actual %0d", e.trans, data[31:16]);
                errors++;
            end
            if (user !== e.tir) begin
                $error("total_internal expected %0d actual %0d", e.tir, user);
                errors++;
            end
        endfunction
    endclass

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         i_s_tvalid = 0;
    logic         o_s_tready;
    logic [111:0] i_s_tdata = 0;
    logic         o_m_tvalid;
    logic         i_m_tready = 0;
    logic [31:0]  o_m_tdata;
    logic         o_m_tuser;

    reflectance_board board = new();
    int  cycles;
    int  hold_off;
    bit  calm;

    fresnel_reflectance dut (.*);

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) board.check_result(o_m_tdata, o_m_tuser);
        if (hold_off > 0) begin
            hold_off   <= hold_off - 1;
            i_m_tready <= 0;
        end else begin
            i_m_tready <= calm || ($urandom_range(99) >= 17);
        end
    end

    function automatic logic [15:0] comp(int q);
        return 16'(q);
    endfunction

    function automatic logic [111:0] pack_item(logic [15:0] ix, logic [15:0] iy,
            logic [15:0] iz, logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
            logic [15:0] ri);
        return {ri, nz, ny, nx, iz, iy, ix};
    endfunction

    task automatic send(logic [111:0] w);
        i_s_tvalid <= 1;
        i_s_tdata  <= w;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        board.note_input(w);
        if (!calm && $urandom_range(99) < 20) begin
            i_s_tvalid <= 0;
            @(posedge i_clk);
        end
    endtask

    function automatic logic [111:0] unit_item(logic [15:0] ri);
        real th, ph, a, b;
        int  ix, iy, iz;
        th = $urandom_range(0, 62831) / 10000.0;
        ph = $urandom_range(0, 31415) / 10000.0;
        ix = $rtoi(16384.0 * $sin(ph) * $cos(th));
        iy = $rtoi(16384.0 * $sin(ph) * $sin(th));
        iz = $rtoi(16384.0 * $cos(ph));
        a = $urandom_range(0, 62831) / 10000.0;
        b = $urandom_range(0, 31415) / 10000.0;
        return pack_item(comp(ix), comp(iy), comp(iz),
            comp($rtoi(16384.0 * $sin(b) * $cos(a))),
            comp($rtoi(16384.0 * $sin(b) * $sin(a))),
            comp($rtoi(16384.0 * $cos(b))), ri);
    endfunction

    function automatic logic [15:0] rand_index();
        int k;
        k = $urandom_range(99);
        if (k < 70) return 16'($urandom_range(4096, 12288));
        if (k < 90) return 16'($urandom_range(1024, 65535));
        return 16'($urandom);
    endfunction

    initial begin
        logic [111:0] w;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        calm    = 1;
        // directed corners
        send(pack_item(16'h4000, 0, 0, 16'hC000, 0, 0, 16'd6144));
        send(pack_item(16'h4000, 0, 0, 16'h4000, 0, 0, 16'd6144));
        send(pack_item(16'h4000, 0, 0, 0, 16'h4000, 0, 16'd6144));
        send(pack_item(16'h2D41, 16'h2D41, 0, 16'h4000, 0, 0, 16'd6144));
        send(pack_item(16'h3F00, 16'h0B00, 0, 16'h4000, 0, 0, 16'd6144));
        send(pack_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF));
        send(pack_item(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF));
        send(pack_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0));
        send(pack_item(16'h4000, 0, 0, 16'hC000, 0, 0, 0));
        send(pack_item(16'h4000, 0, 0, 16'hC000, 0, 0, 16'd4096));
        send(pack_item(16'h4000, 0, 0, 16'h4000, 0, 0, 16'd4096));
        send(pack_item(16'h2D41, 16'h2D41, 0, 16'h4000, 0, 0, 16'd1024));
        send(pack_item(16'h2D41, 16'h2D41, 0, 16'hC000, 0, 0, 16'd1024));
        send(pack_item(0, 0, 0, 0, 0, 0, 16'd5000));
        send(pack_item(16'h0001, 0, 0, 16'hFFFF, 0, 0, 16'h8000));
        calm = 0;
        for (int n = 0; n < 450; n++) begin
            if (n == 120) hold_off = 400;
            calm = (n >= 250 && n < 320);
            if ($urandom_range(99) < 80) w = unit_item(rand_index());
            else w = 112'({$urandom, $urandom, $urandom, $urandom});
            send(w);
        end
        i_s_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (board.errors == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire
